// File: src/httok_pkg.sv
package httok_pkg;

  localparam int unsigned MaxHeaders = 16;
  localparam int unsigned MaxResults = 4;
  localparam logic [4:0] LimitReset = 5'd16;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;

  localparam logic [1:0] EvByte = 2'd0;
  localparam logic [1:0] EvEnd  = 2'd1;
  localparam logic [1:0] EvDone = 2'd2;
  localparam logic [1:0] EvErr  = 2'd3;

  localparam logic [2:0] KindNone  = 3'd0;
  localparam logic [2:0] KindName  = 3'd3;
  localparam logic [2:0] KindValue = 3'd4;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrEnd  = 2'd1;
  localparam logic [1:0] ErrMany = 2'd2;

  typedef enum logic [3:0] {
    PhReq,
    PhLine,
    PhLineCr,
    PhName,
    PhValue,
    PhValLf,
    PhValCr,
    PhValCrlf,
    PhDone
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] line_token;
    logic       token_cut;
    logic [4:0] hdr_count;
    logic       value_started;
  } state_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [2:0] token_kind;
    logic [7:0] out_byte;
    logic [3:0] header_slot;
    logic [4:0] header_total;
    logic [1:0] error_code;
    logic       run_last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] ev, logic [2:0] kind, logic [7:0] data,
                                  logic [3:0] slot, logic [4:0] total, logic [1:0] err);
    res_t r;
    r.event_res    = ev;
    r.token_kind   = kind;
    r.out_byte     = data;
    r.header_slot  = slot;
    r.header_total = total;
    r.error_code   = err;
    r.run_last     = 1'b0;
    return r;
  endfunction

endpackage

// File: src/http_request_header_tokenizer_top.sv
// Tokenizes an HTTP request one byte per beat into method, URI, version and header
// name/value events, ending with a header-complete or error event. An accepted byte
// is registered, decoded combinationally, and its results (zero to four) are loaded into
// an output buffer that hands out one result per beat; the byte is loaded once the
// buffer is empty or is handing out its last result. Bytes that cause at most one result
// are taken at one per cycle while out_ready stays high; a byte that causes several
// results holds back the next byte until the buffer is down to its last result and that
// result is taken. The header limit register must be written only while no message byte is in flight.
module http_request_header_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_res,
  output logic [2:0] token_kind,
  output logic [7:0] out_byte,
  output logic [3:0] header_slot,
  output logic [4:0] header_total,
  output logic [1:0] error_code,
  output logic       run_last
);

  logic              header_limit;
  logic [4:0]        limit_reg;
  logic              inq_valid;
  logic [7:0]        inq_byte;
  logic              inq_last;
  logic              consume;
  logic              can_load;
  httok_pkg::state_t state;
  httok_pkg::state_t state_next;
  logic [2:0]        res_cnt;
  httok_pkg::res_t   res [httok_pkg::MaxResults];
  httok_pkg::res_t   head_res;

  assign header_limit = cfg_wr_en;
  assign consume  = inq_valid && can_load;
  assign in_ready = !inq_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= httok_pkg::LimitReset;
    end else if (header_limit) begin
      limit_reg <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid <= 1'b1;
    end else if (consume) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte <= in_byte;
      inq_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= httok_pkg::PhReq;
      state.line_token    <= 2'd0;
      state.token_cut     <= 1'b0;
      state.hdr_count     <= 5'd0;
      state.value_started <= 1'b0;
    end else if (consume) begin
      state <= state_next;
    end
  end

  httok_step u_step (
    .state        (state),
    .data         (inq_byte),
    .last         (inq_last),
    .header_limit (limit_reg),
    .state_next   (state_next),
    .res_cnt      (res_cnt),
    .res          (res)
  );

  httok_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (consume),
    .load_cnt  (res_cnt),
    .load_res  (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_res  (head_res)
  );

  assign event_res    = head_res.event_res;
  assign token_kind   = head_res.token_kind;
  assign out_byte     = head_res.out_byte;
  assign header_slot  = head_res.header_slot;
  assign header_total = head_res.header_total;
  assign error_code   = head_res.error_code;
  assign run_last     = head_res.run_last;

endmodule

// File: src/httok_step.sv
module httok_step (
  input  httok_pkg::state_t state,
  input  logic [7:0]        data,
  input  logic              last,
  input  logic [4:0]        header_limit,
  output httok_pkg::state_t state_next,
  output logic [2:0]        res_cnt,
  output httok_pkg::res_t   res [httok_pkg::MaxResults]
);

  localparam logic [7:0] MaxH = 8'(httok_pkg::MaxHeaders);

  logic [7:0]        eff_limit;
  httok_pkg::phase_t ph;
  logic [1:0]        lt;
  logic              cut;
  logic [4:0]        cnt;
  logic              vs;
  logic [2:0]        n;
  logic              go_line;
  logic              go_name;
  logic              go_value;
  logic              blank;
  logic              eol;

  assign eff_limit = ({3'b0, header_limit} > MaxH) ? MaxH : {3'b0, header_limit};
  assign blank = (data == httok_pkg::ChSpace) || (data == httok_pkg::ChTab);
  assign eol = (data == httok_pkg::ChLf) || (data == httok_pkg::ChCr);

  always_comb begin
    ph       = state.phase;
    lt       = state.line_token;
    cut      = state.token_cut;
    cnt      = state.hdr_count;
    vs       = state.value_started;
    n        = 3'd0;
    go_line  = 1'b0;
    go_name  = 1'b0;
    go_value = 1'b0;
    for (int i = 0; i < httok_pkg::MaxResults; i++) begin
      res[i] = '0;
    end

    unique case (state.phase)
      httok_pkg::PhReq: begin
        if (last) begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                          4'd0, 5'd0, httok_pkg::ErrEnd);
          n = n + 3'd1;
          ph = httok_pkg::PhDone;
        end else if (data == httok_pkg::ChSpace && lt < 2'd2) begin
          if (!cut) begin
            res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvEnd, {1'b0, lt}, 8'd0,
                                            4'd0, 5'd0, httok_pkg::ErrNone);
            n = n + 3'd1;
          end
          lt = lt + 2'd1;
          cut = 1'b0;
        end else if (data == httok_pkg::ChCr) begin
          if (!cut) begin
            res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvEnd, {1'b0, lt}, 8'd0,
                                            4'd0, 5'd0, httok_pkg::ErrNone);
            n = n + 3'd1;
          end
          cut = 1'b1;
        end else if (data == httok_pkg::ChLf) begin
          if (lt < 2'd2) begin
            res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                            4'd0, 5'd0, httok_pkg::ErrEnd);
            n = n + 3'd1;
            ph = httok_pkg::PhDone;
          end else begin
            if (!cut) begin
              res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvEnd, {1'b0, lt}, 8'd0,
                                              4'd0, 5'd0, httok_pkg::ErrNone);
              n = n + 3'd1;
            end
            cut = 1'b0;
            cnt = 5'd0;
            ph = httok_pkg::PhLine;
          end
        end else if (!cut) begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvByte, {1'b0, lt}, data,
                                          4'd0, 5'd0, httok_pkg::ErrNone);
          n = n + 3'd1;
        end
      end
      httok_pkg::PhLine: begin
        go_line = 1'b1;
      end
      httok_pkg::PhLineCr: begin
        if (data == httok_pkg::ChLf) begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvDone, httok_pkg::KindNone, 8'd0,
                                          4'd0, cnt, httok_pkg::ErrNone);
          n = n + 3'd1;
        end else begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                          4'd0, 5'd0,
                                          ({3'b0, cnt} >= eff_limit) ? httok_pkg::ErrMany
                                                                     : httok_pkg::ErrEnd);
          n = n + 3'd1;
        end
        ph = httok_pkg::PhDone;
      end
      httok_pkg::PhName: begin
        go_name = 1'b1;
      end
      httok_pkg::PhValue: begin
        go_value = 1'b1;
      end
      httok_pkg::PhValLf, httok_pkg::PhValCrlf: begin
        if (blank) begin
          for (int i = 0; i < 3; i++) begin
            if (i < 2 || state.phase == httok_pkg::PhValCrlf) begin
              res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvByte, httok_pkg::KindValue,
                                              httok_pkg::ChSpace, cnt[3:0], 5'd0,
                                              httok_pkg::ErrNone);
              n = n + 3'd1;
            end
          end
          ph = httok_pkg::PhValue;
          if (last) begin
            res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                            4'd0, 5'd0, httok_pkg::ErrEnd);
            n = n + 3'd1;
            ph = httok_pkg::PhDone;
          end
        end else begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvEnd, httok_pkg::KindValue, 8'd0,
                                          cnt[3:0], 5'd0, httok_pkg::ErrNone);
          n = n + 3'd1;
          cnt = cnt + 5'd1;
          ph = httok_pkg::PhLine;
          go_line = 1'b1;
        end
      end
      httok_pkg::PhValCr: begin
        if (data == httok_pkg::ChLf) begin
          if (last) begin
            res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                            4'd0, 5'd0, httok_pkg::ErrEnd);
            n = n + 3'd1;
            ph = httok_pkg::PhDone;
          end else begin
            ph = httok_pkg::PhValCrlf;
          end
        end else begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvByte, httok_pkg::KindValue,
                                          httok_pkg::ChCr, cnt[3:0], 5'd0,
                                          httok_pkg::ErrNone);
          n = n + 3'd1;
          go_value = 1'b1;
        end
      end
      httok_pkg::PhDone: begin
        ph = httok_pkg::PhDone;
      end
      default: begin
        ph = httok_pkg::PhDone;
      end
    endcase

    if (go_line) begin
      if (data == httok_pkg::ChLf) begin
        res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvDone, httok_pkg::KindNone, 8'd0,
                                        4'd0, cnt, httok_pkg::ErrNone);
        n = n + 3'd1;
        ph = httok_pkg::PhDone;
      end else if (data == httok_pkg::ChCr) begin
        if (last) begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                          4'd0, 5'd0, httok_pkg::ErrEnd);
          n = n + 3'd1;
          ph = httok_pkg::PhDone;
        end else begin
          ph = httok_pkg::PhLineCr;
        end
      end else if ({3'b0, cnt} >= eff_limit) begin
        res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                        4'd0, 5'd0, httok_pkg::ErrMany);
        n = n + 3'd1;
        ph = httok_pkg::PhDone;
      end else begin
        cut = 1'b0;
        ph = httok_pkg::PhName;
        go_name = 1'b1;
      end
    end

    if (go_name) begin
      if (eol) begin
        res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                        4'd0, 5'd0, httok_pkg::ErrEnd);
        n = n + 3'd1;
        ph = httok_pkg::PhDone;
      end else begin
        if (data == httok_pkg::ChColon) begin
          if (!cut) begin
            res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvEnd, httok_pkg::KindName, 8'd0,
                                            cnt[3:0], 5'd0, httok_pkg::ErrNone);
            n = n + 3'd1;
          end
          cut = 1'b0;
          vs = 1'b0;
          ph = httok_pkg::PhValue;
        end else if (blank) begin
          if (!cut) begin
            res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvEnd, httok_pkg::KindName, 8'd0,
                                            cnt[3:0], 5'd0, httok_pkg::ErrNone);
            n = n + 3'd1;
          end
          cut = 1'b1;
        end else if (!cut) begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvByte, httok_pkg::KindName, data,
                                          cnt[3:0], 5'd0, httok_pkg::ErrNone);
          n = n + 3'd1;
        end
        if (last) begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                          4'd0, 5'd0, httok_pkg::ErrEnd);
          n = n + 3'd1;
          ph = httok_pkg::PhDone;
        end
      end
    end

    if (go_value) begin
      ph = httok_pkg::PhValue;
      if (eol) begin
        vs = 1'b1;
        if (last) begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                          4'd0, 5'd0, httok_pkg::ErrEnd);
          n = n + 3'd1;
          ph = httok_pkg::PhDone;
        end else if (data == httok_pkg::ChLf) begin
          ph = httok_pkg::PhValLf;
        end else begin
          ph = httok_pkg::PhValCr;
        end
      end else begin
        if (vs || !blank) begin
          vs = 1'b1;
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvByte, httok_pkg::KindValue, data,
                                          cnt[3:0], 5'd0, httok_pkg::ErrNone);
          n = n + 3'd1;
        end
        if (last) begin
          res[n[1:0]] = httok_pkg::mk_res(httok_pkg::EvErr, httok_pkg::KindNone, 8'd0,
                                          4'd0, 5'd0, httok_pkg::ErrEnd);
          n = n + 3'd1;
          ph = httok_pkg::PhDone;
        end
      end
    end

    if (n != 3'd0) begin
      res[2'(n - 3'd1)].run_last = 1'b1;
    end

    if (last) begin
      ph  = httok_pkg::PhReq;
      lt  = 2'd0;
      cut = 1'b0;
      cnt = 5'd0;
      vs  = 1'b0;
    end

    state_next.phase         = ph;
    state_next.line_token    = lt;
    state_next.token_cut     = cut;
    state_next.hdr_count     = cnt;
    state_next.value_started = vs;
    res_cnt                  = n;
  end

endmodule

// File: src/httok_obuf.sv
module httok_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [2:0]      load_cnt,
  input  httok_pkg::res_t load_res [httok_pkg::MaxResults],
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output httok_pkg::res_t head_res
);

  httok_pkg::res_t buf_res [httok_pkg::MaxResults];
  logic [2:0]      cnt;
  logic [1:0]      head;
  logic            pop;

  assign out_valid = (cnt != 3'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt == 3'd0) || (cnt == 3'd1 && out_ready);
  assign head_res  = buf_res[head];

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < httok_pkg::MaxResults; i++) begin
        buf_res[i] <= load_res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 3'd0;
      head <= 2'd0;
    end else if (load) begin
      cnt  <= load_cnt;
      head <= 2'd0;
    end else if (pop) begin
      cnt  <= cnt - 3'd1;
      head <= head + 2'd1;
    end
  end

endmodule

// File: tb/sv/httok_event_checker.sv
module httok_event_checker
  import httok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] event_res,
  input  logic [2:0] token_kind,
  input  logic [7:0] out_byte,
  input  logic [3:0] header_slot,
  input  logic [4:0] header_total,
  input  logic [1:0] error_code,
  input  logic       run_last,
  output int         mismatches,
  output int         awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t     ph;
  logic [1:0] tok_idx;
  logic       tok_cut;
  logic [4:0] hdr_n;
  logic       val_begun;
  logic [4:0] hdr_limit;
  res_t       beat_events[$];
  res_t       expected_events[$];

  function automatic logic is_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab;
  endfunction

  function automatic logic at_limit();
    return hdr_n >= ((hdr_limit > MaxHeaders) ? MaxHeaders : hdr_limit);
  endfunction

  task automatic add_event(logic [1:0] ev, logic [2:0] kind, logic [7:0] data,
                           logic [3:0] slot, logic [4:0] total, logic [1:0] err);
    res_t r;
    r.event_res    = ev;
    r.token_kind   = kind;
    r.out_byte     = data;
    r.header_slot  = slot;
    r.header_total = total;
    r.error_code   = err;
    r.run_last     = 1'b0;
    if (beat_events.size() < MaxResults) beat_events.push_back(r);
  endtask

  task automatic abort(logic [1:0] err);
    add_event(EvErr, KindNone, 8'h00, 4'd0, 5'd0, err);
    ph = PhDone;
  endtask

  task automatic slot_event(logic [1:0] ev, logic [2:0] kind, logic [7:0] data);
    add_event(ev, kind, data, hdr_n[3:0], 5'd0, ErrNone);
  endtask

  task automatic request_char(logic [7:0] c, logic last);
    if (last) begin
      abort(ErrEnd);
    end else if (c == ChSpace && tok_idx < 2'd2) begin
      if (!tok_cut) add_event(EvEnd, {1'b0, tok_idx}, 8'h00, 4'd0, 5'd0, ErrNone);
      tok_idx++;
      tok_cut = 1'b0;
    end else if (c == ChCr) begin
      if (!tok_cut) add_event(EvEnd, {1'b0, tok_idx}, 8'h00, 4'd0, 5'd0, ErrNone);
      tok_cut = 1'b1;
    end else if (c == ChLf) begin
      if (tok_idx < 2'd2) begin
        abort(ErrEnd);
      end else begin
        if (!tok_cut) add_event(EvEnd, {1'b0, tok_idx}, 8'h00, 4'd0, 5'd0, ErrNone);
        tok_cut = 1'b0;
        hdr_n = 5'd0;
        ph = PhLine;
      end
    end else if (!tok_cut) begin
      add_event(EvByte, {1'b0, tok_idx}, c, 4'd0, 5'd0, ErrNone);
    end
  endtask

  task automatic name_char(logic [7:0] c, logic last);
    if (c == ChLf || c == ChCr) begin
      abort(ErrEnd);
    end else begin
      if (c == ChColon) begin
        if (!tok_cut) slot_event(EvEnd, KindName, 8'h00);
        tok_cut = 1'b0;
        val_begun = 1'b0;
        ph = PhValue;
      end else if (is_blank(c)) begin
        if (!tok_cut) slot_event(EvEnd, KindName, 8'h00);
        tok_cut = 1'b1;
      end else if (!tok_cut) begin
        slot_event(EvByte, KindName, c);
      end
      if (last) abort(ErrEnd);
    end
  endtask

  task automatic line_begin(logic [7:0] c, logic last);
    if (c == ChLf) begin
      add_event(EvDone, KindNone, 8'h00, 4'd0, hdr_n, ErrNone);
      ph = PhDone;
    end else if (c == ChCr) begin
      if (last) abort(ErrEnd);
      else ph = PhLineCr;
    end else if (at_limit()) begin
      abort(ErrMany);
    end else begin
      tok_cut = 1'b0;
      ph = PhName;
      name_char(c, last);
    end
  endtask

  task automatic value_char(logic [7:0] c, logic last);
    ph = PhValue;
    if (c == ChLf || c == ChCr) begin
      val_begun = 1'b1;
      if (last) abort(ErrEnd);
      else if (c == ChLf) ph = PhValLf;
      else ph = PhValCr;
    end else begin
      if (val_begun || !is_blank(c)) begin
        val_begun = 1'b1;
        slot_event(EvByte, KindValue, c);
      end
      if (last) abort(ErrEnd);
    end
  endtask

  task automatic close_value(logic [7:0] c, logic last);
    slot_event(EvEnd, KindValue, 8'h00);
    hdr_n++;
    ph = PhLine;
    line_begin(c, last);
  endtask

  task automatic fold_spaces(int unsigned n, logic last);
    repeat (n) slot_event(EvByte, KindValue, ChSpace);
    ph = PhValue;
    if (last) abort(ErrEnd);
  endtask

  task automatic tokenize_byte(logic [7:0] c, logic last);
    res_t tail;
    beat_events.delete();
    case (ph)
      PhReq: request_char(c, last);
      PhLine: line_begin(c, last);
      PhLineCr: begin
        if (c == ChLf) begin
          add_event(EvDone, KindNone, 8'h00, 4'd0, hdr_n, ErrNone);
          ph = PhDone;
        end else begin
          abort(at_limit() ? ErrMany : ErrEnd);
        end
      end
      PhName: name_char(c, last);
      PhValue: value_char(c, last);
      PhValLf: begin
        if (is_blank(c)) fold_spaces(2, last);
        else close_value(c, last);
      end
      PhValCr: begin
        if (c == ChLf) begin
          if (last) abort(ErrEnd);
          else ph = PhValCrlf;
        end else begin
          slot_event(EvByte, KindValue, ChCr);
          value_char(c, last);
        end
      end
      PhValCrlf: begin
        if (is_blank(c)) fold_spaces(3, last);
        else close_value(c, last);
      end
      default: ph = PhDone;
    endcase
    if (beat_events.size() > 0) begin
      tail = beat_events.pop_back();
      tail.run_last = 1'b1;
      beat_events.push_back(tail);
    end
    foreach (beat_events[i]) expected_events.push_back(beat_events[i]);
    if (last) begin
      ph = PhReq;
      tok_idx = 2'd0;
      tok_cut = 1'b0;
      hdr_n = 5'd0;
      val_begun = 1'b0;
    end
  endtask

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      ph = PhReq;
      tok_idx = 2'd0;
      tok_cut = 1'b0;
      hdr_n = 5'd0;
      val_begun = 1'b0;
      hdr_limit = LimitReset;
      expected_events.delete();
    end else begin
      if (cfg_wr_en) hdr_limit = cfg_wr_data;
      if (in_valid && in_ready) tokenize_byte(in_byte, in_last);
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("Result beat with nothing expected: event_res %0d, token_kind %0d",
                 event_res, token_kind);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", want.event_res, event_res);
          check_field("token_kind", want.token_kind, token_kind);
          check_field("out_byte", want.out_byte, out_byte);
          check_field("header_slot", want.header_slot, header_slot);
          check_field("header_total", want.header_total, header_total);
          check_field("error_code", want.error_code, error_code);
          check_field("run_last", want.run_last, run_last);
        end
      end
    end
    awaited <= expected_events.size();
  end

endmodule

// File: tb/sv/http_request_header_tokenizer_top_test.sv
module http_request_header_tokenizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import httok_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseBeats = 36;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = 5'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] event_res;
  logic [2:0] token_kind;
  logic [7:0] out_byte;
  logic [3:0] header_slot;
  logic [4:0] header_total;
  logic [1:0] error_code;
  logic       run_last;

  int mismatches;
  int awaited;
  int gap_pct = 0;
  int stall_pct = 0;
  int phase_beats = 0;
  int cycles = 0;

  logic [7:0] msg[$];
  logic [4:0] limits[6];
  string drills[$] = '{
    "G / H\n\n",
    "A B\nZ",
    "G",
    "M\015x U V\015\nN: \011v\n \015\n\011w\015x\n\n",
    "M U V\nN\011m:v\015",
    "M U V\n\015x",
    "M U V\n\015",
    "M U V\nN\015",
    "M U V\nNa",
    "M U V\nN:v\n",
    "M U V\nN:v\015\n",
    "M U V\nN:v\n ",
    "M U V\nN:\n\015\n"
  };

  http_request_header_tokenizer_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .token_kind  (token_kind),
    .out_byte    (out_byte),
    .header_slot (header_slot),
    .header_total(header_total),
    .error_code  (error_code),
    .run_last    (run_last)
  );

  httok_event_checker tokens_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .token_kind  (token_kind),
    .out_byte    (out_byte),
    .header_slot (header_slot),
    .header_total(header_total),
    .error_code  (error_code),
    .run_last    (run_last),
    .mismatches  (mismatches),
    .awaited     (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("http_request_header_tokenizer_top_test failed");
    $finish;
  end

  function automatic logic [7:0] pick(int unsigned lo, int unsigned hi);
    logic [7:0] b;
    b = $urandom_range(hi, lo);
    return b;
  endfunction

  function automatic logic [7:0] any_blank();
    return $urandom_range(1, 0) ? ChSpace : ChTab;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_beat(logic [7:0] b, logic last);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phase_beats++;
  endtask

  task automatic send_msg();
    foreach (msg[i]) begin
      if ($urandom_range(149, 0) == 0) drain();
      send_beat(msg[i], i == msg.size() - 1);
    end
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic add_eol();
    if ($urandom_range(1, 0)) msg.push_back(ChCr);
    msg.push_back(ChLf);
  endtask

  task automatic build_request(int unsigned cap);
    int unsigned n_hdr;
    logic [7:0] b;
    msg.delete();
    repeat ($urandom_range(1, 4)) msg.push_back(pick(8'h41, 8'h5A));
    if ($urandom_range(7, 0) == 0) begin
      msg.push_back(ChCr);
      msg.push_back(pick(8'h21, 8'hFF));
    end
    msg.push_back(ChSpace);
    repeat ($urandom_range(1, 5)) msg.push_back(pick(8'h21, 8'hFF));
    msg.push_back(ChSpace);
    add_str("HTTP/1.");
    msg.push_back(pick(8'h30, 8'h39));
    add_eol();
    n_hdr = ($urandom_range(7, 0) == 0) ? cap + 1 : $urandom_range(0, 3);
    repeat (n_hdr) begin
      repeat ($urandom_range(1, 4)) begin
        b = pick(8'h21, 8'hFF);
        msg.push_back(b == ChColon ? 8'h6E : b);
      end
      if ($urandom_range(7, 0) == 0) begin
        msg.push_back(any_blank());
        msg.push_back(pick(8'h21, 8'h39));
      end
      msg.push_back(ChColon);
      repeat ($urandom_range(0, 2)) msg.push_back(any_blank());
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(11, 0))
          0: begin
            add_eol();
            msg.push_back(any_blank());
          end
          1: begin
            msg.push_back(ChCr);
            msg.push_back(pick(8'h20, 8'hFF));
          end
          2: msg.push_back(ChTab);
          default: msg.push_back(pick(8'h20, 8'hFF));
        endcase
      end
      add_eol();
    end
    if ($urandom_range(11, 0) == 0) begin
      msg.push_back(ChCr);
      msg.push_back(pick(8'h20, 8'hFF));
    end else begin
      add_eol();
    end
    if ($urandom_range(3, 0) == 0) begin
      repeat ($urandom_range(1, 3)) msg.push_back(pick(0, 255));
    end
  endtask

  task automatic build_noise();
    msg.delete();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(7, 0))
        0: msg.push_back(ChCr);
        1: msg.push_back(ChLf);
        2: msg.push_back(any_blank());
        3: msg.push_back(ChColon);
        default: msg.push_back(pick(0, 255));
      endcase
    end
  endtask

  initial begin
    int unsigned cap;
    int unsigned cut;
    int unsigned shape;
    limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd3};
    limits[4] = $urandom_range(2, 15);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      cap = (limits[p] > MaxHeaders) ? MaxHeaders : limits[p];
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 48;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 48;
        end
        default: begin
          gap_pct = 15;
          stall_pct = 15;
        end
      endcase
      phase_beats = 0;
      if (p == 0) begin
        foreach (drills[i]) begin
          msg.delete();
          add_str(drills[i]);
          send_msg();
        end
        msg = '{8'h00, ChSpace, 8'hFF, ChSpace, 8'h80, ChLf,
                8'h7F, ChColon, 8'hFF, ChLf, ChLf};
        send_msg();
        phase_beats = 0;
      end
      while (phase_beats < PhaseBeats) begin
        shape = $urandom_range(9, 0);
        if (shape == 0) begin
          build_noise();
        end else begin
          build_request(cap);
          if (shape < 3) begin
            cut = $urandom_range(msg.size() - 1, 0);
            while (msg.size() > cut + 1) void'(msg.pop_back());
          end
        end
        send_msg();
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("http_request_header_tokenizer_top_test passed");
    end else begin
      $display("http_request_header_tokenizer_top_test failed");
    end
    $finish;
  end

endmodule
